[sv/tsed_pkg.sv]
// shared constants for the texture screen error diffusion halftoner
package tsed_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WEFF_W    = COL_W + 1;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int WIDTH_W   = 12;
	localparam int GAIN_W    = 12;
	localparam int BAND_W    = 7;
	localparam int ERR_W     = 13;
	localparam int ACC_W     = 27;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_ERROR_GAIN    = 3'd2;
	localparam logic [2:0] REG_EDGE_BAND     = 3'd3;
	localparam logic [2:0] REG_TEXTURE_SPLIT = 3'd4;

	localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT  = 16'd480;
	localparam logic [GAIN_W-1:0]  RST_ERROR_GAIN    = 12'd256;
	localparam logic [BAND_W-1:0]  RST_EDGE_BAND     = 7'd0;
	localparam logic [PIX_W-1:0]   RST_TEXTURE_SPLIT = 8'd128;

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

endpackage

[sv/texture_screen_error_diffusion.sv]
// texture screen error diffusion halftoner: line error memory, two stage datapath, apb registers
// a result passes through the stage 1, stage 2 and output registers after its input beat is accepted
// throughput: one pixel per cycle for widths of four and more while the output does not stall, set by the single
//   write port of the line error memory and its read-modify-write distance
// widths below four: an interlock holds each new pixel until the pipeline is empty and the writeback has landed
// reset: registers to their defaults, position and pending errors to zero; the line
//   error memory is not cleared, reads in the first row of an image are taken as zero
module texture_screen_error_diffusion (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsed_pkg::ADDR_W-1:0]   paddr,
	input  logic [tsed_pkg::DATA_W-1:0]   pwdata,
	output logic [tsed_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tsed_pkg::PIX_W-1:0]    pixel,
	input  logic [tsed_pkg::PIX_W-1:0]    screen_one,
	input  logic [tsed_pkg::PIX_W-1:0]    screen_two,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tsed_pkg::PIX_W-1:0]    out_pixel,
	output logic                          end_of_image
);
	import tsed_pkg::*;

	// configuration
	logic [WIDTH_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [BAND_W-1:0]  band_q;
	logic [PIX_W-1:0]   split_q;
	logic [2:0]         cfg_idx;
	logic               cfg_wr;
	logic               size_clear;

	// position and diffusion state
	logic [COL_W-1:0]        column_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [11:0]      pend_left_q;
	logic signed [8:0]       pend_here_q;
	logic                    q_last_q;
	logic [PIX_W-1:0]        p_last_q;
	logic [WEFF_W-1:0]       w_eff;
	logic [ROW_W-1:0]        h_eff;
	logic                    last_col;
	logic                    last_row;
	logic                    w_small;
	logic [PIX_W-1:0]        thresh;

	// line error memory
	logic signed [ERR_W-1:0] err_line [MAX_WIDTH];
	logic signed [ERR_W-1:0] rd_q;
	logic                    defer_q;
	logic [COL_W-1:0]        defer_addr_q;
	logic signed [ERR_W-1:0] defer_data_q;

	// handshake
	logic in_acc;
	logic out_load;
	logic s2_take;
	logic s1_move;
	logic s1_free;
	logic lock;

	// stage 1
	logic               s1_valid_q;
	logic [PIX_W-1:0]   pix_s1;
	logic [PIX_W-1:0]   thr_s1;
	logic [PIX_W-1:0]   pprev_s1;
	logic [COL_W-1:0]   col_s1;
	logic               xnz_s1;
	logic               lastc_s1;
	logic               lastr_s1;
	logic               row0_s1;
	logic signed [ERR_W-1:0] m_val;
	logic signed [8:0]       diff;
	logic signed [25:0]      prod_m;
	logic signed [ACC_W-1:0] a_val;
	logic [14:0]             g7;
	logic [22:0]             b0;
	logic [22:0]             g7x255;
	logic signed [23:0]      b1;

	// stage 2
	logic                    s2_valid_q;
	logic [PIX_W-1:0]        pix_s2;
	logic [COL_W-1:0]        col_s2;
	logic                    xnz_s2;
	logic                    lastc_s2;
	logic                    lastr_s2;
	logic signed [ACC_W-1:0] a_s2;
	logic [22:0]             b0_s2;
	logic signed [23:0]      b1_s2;
	logic signed [ACC_W-1:0] re;
	logic signed [ACC_W-1:0] tot;
	logic                    q_hi;
	logic signed [8:0]       err;
	logic signed [11:0]      err3;
	logic signed [11:0]      err5;
	logic signed [11:0]      pl_new;
	logic signed [ERR_W-1:0] wr_below;
	logic [COL_W-1:0]        wr_addr;
	logic                    s2_wr;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             eoi_q;

	// ---------------------------------------------------------------- registers

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign size_clear = cfg_wr && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			gain_q   <= RST_ERROR_GAIN;
			band_q   <= RST_EDGE_BAND;
			split_q  <= RST_TEXTURE_SPLIT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:   width_q  <= pwdata[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= pwdata[ROW_W-1:0];
				REG_ERROR_GAIN:    gain_q   <= pwdata[GAIN_W-1:0];
				REG_EDGE_BAND:     band_q   <= pwdata[BAND_W-1:0];
				REG_TEXTURE_SPLIT: split_q  <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_IMAGE_WIDTH:   prdata = DATA_W'(width_q);
			REG_IMAGE_HEIGHT:  prdata = DATA_W'(height_q);
			REG_ERROR_GAIN:    prdata = DATA_W'(gain_q);
			REG_EDGE_BAND:     prdata = DATA_W'(band_q);
			REG_TEXTURE_SPLIT: prdata = DATA_W'(split_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake

	assign out_load = s2_valid_q && (!out_valid_q || !out_stall);
	assign s2_take  = !s2_valid_q || out_load;
	assign s1_move  = s1_valid_q && s2_take;
	assign s1_free  = !s1_valid_q || s2_take;
	// narrow images reread an entry before its writeback lands
	assign lock     = w_small && (s1_valid_q || s2_valid_q || defer_q);
	assign in_stall = !s1_free || lock;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				s1_valid_q <= 1'b1;
			else if (s1_move)
				s1_valid_q <= 1'b0;
			if (s1_move)
				s2_valid_q <= 1'b1;
			else if (out_load)
				s2_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- position

	always_comb begin
		if (width_q == '0)
			w_eff = WEFF_W'(1);
		else if (width_q > WIDTH_W'(MAX_WIDTH))
			w_eff = WEFF_W'(MAX_WIDTH);
		else
			w_eff = WEFF_W'(width_q);
	end

	assign h_eff    = (height_q == '0) ? ROW_W'(1) : height_q;
	assign last_col = (WEFF_W'(column_q) + WEFF_W'(1)) >= w_eff;
	assign last_row = ((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
	assign w_small  = w_eff <= WEFF_W'(3);

	always_comb begin
		if (pixel < PIX_W'(band_q))
			thresh = screen_one;
		else if (pixel > (PIX_WHITE - PIX_W'(band_q)))
			thresh = screen_two;
		else
			thresh = (screen_one <= split_q) ? screen_one : screen_two;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (size_clear) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- memory

	assign wr_addr = col_s2 - COL_W'(1);
	assign s2_wr   = out_load && xnz_s2;

	always_ff @(posedge clk) begin
		if (in_acc)
			rd_q <= err_line[column_q];
		if (s2_wr)
			err_line[wr_addr] <= wr_below;
		else if (defer_q)
			err_line[defer_addr_q] <= defer_data_q;
	end

	// ---------------------------------------------------------------- stage 1

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1   <= pixel;
			thr_s1   <= thresh;
			pprev_s1 <= p_last_q;
			p_last_q <= pixel;
			col_s1   <= column_q;
			xnz_s1   <= column_q != '0;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
			row0_s1  <= row_q == '0;
		end
	end

	// first row of an image sees no error from above
	assign m_val  = row0_s1 ? '0 : rd_q;
	assign diff   = $signed({1'b0, pix_s1}) - $signed({1'b0, thr_s1});
	assign prod_m = $signed({1'b0, gain_q}) * m_val;
	assign a_val  = (ACC_W'(diff) <<< 12) + ACC_W'(prod_m);

	// both candidates of the right neighbour share, gain*7*err with err = p or p-255
	assign g7     = {gain_q, 3'b000} - 15'(gain_q);
	assign b0     = g7 * pprev_s1;
	assign g7x255 = {g7, 8'b0000_0000} - 23'(g7);
	assign b1     = $signed({1'b0, b0}) - $signed({1'b0, g7x255});

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pix_s2   <= pix_s1;
			col_s2   <= col_s1;
			xnz_s2   <= xnz_s1;
			lastc_s2 <= lastc_s1;
			lastr_s2 <= lastr_s1;
			a_s2     <= a_val;
			b0_s2    <= b0;
			b1_s2    <= b1;
		end
	end

	// ---------------------------------------------------------------- stage 2

	always_comb begin
		if (!xnz_s2)
			re = '0;
		else if (q_last_q)
			re = ACC_W'(b1_s2);
		else
			re = ACC_W'($signed({1'b0, b0_s2}));
	end

	assign tot      = a_s2 + re;
	assign q_hi     = !tot[ACC_W-1] && (tot != '0);
	assign err      = q_hi ? ($signed({1'b0, pix_s2}) - 9'sd255) : $signed({1'b0, pix_s2});
	assign err3     = 12'(err) * 12'sd3;
	assign err5     = 12'(err) * 12'sd5;
	assign pl_new   = 12'(pend_here_q) + err5;
	assign wr_below = lastr_s2 ? '0 : (ERR_W'(pend_left_q) + ERR_W'(err3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_left_q <= '0;
			pend_here_q <= '0;
			q_last_q    <= 1'b0;
			defer_q     <= 1'b0;
		end else begin
			defer_q <= out_load && lastc_s2;
			if (size_clear) begin
				pend_left_q <= '0;
				pend_here_q <= '0;
			end else if (out_load) begin
				q_last_q <= q_hi;
				if (lastc_s2) begin
					pend_left_q <= '0;
					pend_here_q <= '0;
				end else begin
					pend_left_q <= pl_new;
					pend_here_q <= err;
				end
			end
		end
	end

	// the last column writes its own entry in the next cycle, the port is free then
	always_ff @(posedge clk) begin
		if (out_load && lastc_s2) begin
			defer_addr_q <= col_s2;
			defer_data_q <= lastr_s2 ? '0 : ERR_W'(pl_new);
		end
	end

	// ---------------------------------------------------------------- output beat

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pixel_q <= q_hi ? PIX_WHITE : '0;
			eoi_q       <= lastc_s2 && lastr_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign end_of_image = eoi_q;

endmodule
